// ===== hdl/psds_pkg.sv =====
// Shared constants for the point to segment squared distance block.
// No dependencies; the top level takes its parameter defaults from here.
package psds_pkg;

	localparam int DEFAULT_COORD_BITS    = 16;
	localparam int DEFAULT_FRACTION_BITS = 16;

	// Legal parameter ranges.
	localparam int MIN_COORD_BITS    = 8;
	localparam int MAX_COORD_BITS    = 24;
	localparam int MIN_FRACTION_BITS = 8;
	localparam int MAX_FRACTION_BITS = 24;

endpackage

// ===== hdl/point_segment_distance_squared.sv =====
// Point to segment squared distance, fully pipelined.
// Depends on psds_pkg for parameter defaults.
//
// Usage: the input channel (in_valid/in_ready) carries one request with a
// query point and the start and end points of a segment, all signed fixed
// point of COORD_BITS bits. The output channel (out_valid/out_ready) returns
// the squared distance from the point to the nearest point of the segment,
// 2*COORD_BITS+1 bits unsigned, one result per request, in request order.
// The segment parameter is a restoring division done one quotient bit per
// pipeline stage, so the pipeline is FRACTION_BITS+9 registers deep. A new
// request is accepted every cycle while the receiver keeps up, so the
// throughput is one request per cycle.
// When out_ready is low with a result waiting, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated and in_ready returns as soon
// as the waiting result is taken. While the output register is empty the
// pipeline keeps moving and bubbles are simply carried along.
// Reset (arst_n low) clears every stage valid bit at once; the block then
// accepts requests in the first cycle after reset is released.
// A zero-length segment gives the squared distance to its start point.
module point_segment_distance_squared #(
	parameter int COORD_BITS    = psds_pkg::DEFAULT_COORD_BITS,
	parameter int FRACTION_BITS = psds_pkg::DEFAULT_FRACTION_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_BITS-1:0]  point_x,
	input  logic signed [COORD_BITS-1:0]  point_y,
	input  logic signed [COORD_BITS-1:0]  start_x,
	input  logic signed [COORD_BITS-1:0]  start_y,
	input  logic signed [COORD_BITS-1:0]  end_x,
	input  logic signed [COORD_BITS-1:0]  end_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2*COORD_BITS:0]         distance_squared
);

	localparam int D_W    = COORD_BITS + 1;           // p and d components
	localparam int PP_W   = 2 * D_W;                  // one product
	localparam int DOT_W  = 2 * COORD_BITS + 3;       // dot, signed
	localparam int LEN_W  = 2 * COORD_BITS + 2;       // len2, unsigned
	localparam int REM_W  = DOT_W;                    // remainder after shift
	localparam int PROD_W = D_W + FRACTION_BITS + 2;  // d * t
	localparam int V_W    = COORD_BITS + 2;           // p - q
	localparam int SQ_W   = 2 * V_W;
	localparam int OUT_W  = 2 * COORD_BITS + 1;

	localparam logic [FRACTION_BITS:0] T_ONE = {1'b1, {FRACTION_BITS{1'b0}}};
	localparam logic signed [PROD_W-1:0] HALF =
		PROD_W'(64'd1 << (FRACTION_BITS - 1));

	typedef struct packed {
		logic signed [D_W-1:0] px;
		logic signed [D_W-1:0] py;
		logic signed [D_W-1:0] dx;
		logic signed [D_W-1:0] dy;
	} geo_t;

	typedef struct packed {
		logic zero;   // t forced to 0
		logic full;   // t forced to one
	} clamp_t;

	logic adv;

	// Stage 1: offsets from the segment start.
	logic vld_s1;
	geo_t geo_s1;

	// Stage 2: four products.
	logic                   vld_s2;
	geo_t                   geo_s2;
	logic signed [PP_W-1:0] pxdx_s2, pydy_s2, dxdx_s2, dydy_s2;

	// Stage 3: dot and squared length.
	logic                    vld_s3;
	geo_t                    geo_s3;
	logic signed [DOT_W-1:0] dot_s3;
	logic [LEN_W-1:0]        len2_s3;

	// Stage 4: clamp decision and divider setup.
	logic             vld_s4;
	geo_t             geo_s4;
	clamp_t           clamp_s4;
	logic [REM_W-1:0] rem_s4;
	logic [LEN_W-1:0] den_s4;

	// Stage group 5: one quotient bit per entry.
	logic                     div_vld_s5   [FRACTION_BITS];
	geo_t                     div_geo_s5   [FRACTION_BITS];
	clamp_t                   div_clamp_s5 [FRACTION_BITS];
	logic [REM_W-1:0]         div_rem_s5   [FRACTION_BITS];
	logic [LEN_W-1:0]         div_den_s5   [FRACTION_BITS];
	logic [FRACTION_BITS-1:0] div_q_s5     [FRACTION_BITS];

	// Stage 6: clamped parameter.
	logic                   vld_s6;
	geo_t                   geo_s6;
	logic [FRACTION_BITS:0] t_s6;

	// Stage 7: d * t.
	logic                     vld_s7;
	geo_t                     geo_s7;
	logic signed [PROD_W-1:0] dxt_s7, dyt_s7;

	// Stage 8: residual p - q.
	logic                  vld_s8;
	logic signed [V_W-1:0] vx_s8, vy_s8;

	// Stage 9: squares.
	logic                   vld_s9;
	logic signed [SQ_W-1:0] sqx_s9, sqy_s9;

	// Stage 10: output register.
	logic             vld_s10;
	logic [OUT_W-1:0] dist_s10;

	// The whole pipeline moves unless a finished result is being held.
	assign adv       = !vld_s10 || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_s10;
	assign distance_squared = dist_s10;

	// Combinational helpers.
	logic signed [DOT_W-1:0]  dot_c;
	logic signed [DOT_W-1:0]  len2_c;
	clamp_t                   clamp_c;
	logic signed [PROD_W-1:0] offx_c, offy_c, vx_full_c, vy_full_c;
	logic signed [SQ_W-1:0]   dist_sum_c;

	always_comb begin
		dot_c  = DOT_W'(pxdx_s2) + DOT_W'(pydy_s2);
		len2_c = DOT_W'(dxdx_s2) + DOT_W'(dydy_s2);

		clamp_c.zero = (len2_s3 == '0) || dot_s3[DOT_W-1] || (dot_s3 == '0);
		clamp_c.full = !clamp_c.zero && (dot_s3 >= $signed({1'b0, len2_s3}));

		// Round to nearest, ties upward: add one half, then floor shift.
		offx_c    = (dxt_s7 + HALF) >>> FRACTION_BITS;
		offy_c    = (dyt_s7 + HALF) >>> FRACTION_BITS;
		vx_full_c = PROD_W'(geo_s7.px) - offx_c;
		vy_full_c = PROD_W'(geo_s7.py) - offy_c;

		dist_sum_c = sqx_s9 + sqy_s9;
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s6  <= div_vld_s5[FRACTION_BITS-1];
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s1.px <= D_W'(point_x) - D_W'(start_x);
			geo_s1.py <= D_W'(point_y) - D_W'(start_y);
			geo_s1.dx <= D_W'(end_x) - D_W'(start_x);
			geo_s1.dy <= D_W'(end_y) - D_W'(start_y);

			geo_s2  <= geo_s1;
			pxdx_s2 <= PP_W'(geo_s1.px) * PP_W'(geo_s1.dx);
			pydy_s2 <= PP_W'(geo_s1.py) * PP_W'(geo_s1.dy);
			dxdx_s2 <= PP_W'(geo_s1.dx) * PP_W'(geo_s1.dx);
			dydy_s2 <= PP_W'(geo_s1.dy) * PP_W'(geo_s1.dy);

			geo_s3  <= geo_s2;
			dot_s3  <= dot_c;
			len2_s3 <= len2_c[LEN_W-1:0];

			geo_s4   <= geo_s3;
			clamp_s4 <= clamp_c;
			rem_s4   <= dot_s3;
			den_s4   <= len2_s3;

			geo_s6 <= div_geo_s5[FRACTION_BITS-1];
			if (div_clamp_s5[FRACTION_BITS-1].full) begin
				t_s6 <= T_ONE;
			end else if (div_clamp_s5[FRACTION_BITS-1].zero) begin
				t_s6 <= '0;
			end else begin
				t_s6 <= {1'b0, div_q_s5[FRACTION_BITS-1]};
			end

			geo_s7 <= geo_s6;
			dxt_s7 <= PROD_W'(geo_s6.dx) * PROD_W'($signed({1'b0, t_s6}));
			dyt_s7 <= PROD_W'(geo_s6.dy) * PROD_W'($signed({1'b0, t_s6}));

			vx_s8 <= vx_full_c[V_W-1:0];
			vy_s8 <= vy_full_c[V_W-1:0];

			sqx_s9 <= SQ_W'(vx_s8) * SQ_W'(vx_s8);
			sqy_s9 <= SQ_W'(vy_s8) * SQ_W'(vy_s8);

			dist_s10 <= dist_sum_c[OUT_W-1:0];
		end
	end

	// Restoring divider: each stage shifts the remainder left by one and
	// subtracts the divisor when it fits. The remainder stays below the
	// divisor whenever the quotient is actually used.
	for (genvar k = 0; k < FRACTION_BITS; k++) begin : g_div
		logic                     vld_in;
		geo_t                     geo_in;
		clamp_t                   clamp_in;
		logic [REM_W-1:0]         rem_in;
		logic [LEN_W-1:0]         den_in;
		logic [FRACTION_BITS-1:0] q_in;
		logic [REM_W-1:0]         rem_sh;
		logic                     fits;

		if (k == 0) begin : g_first
			assign vld_in   = vld_s4;
			assign geo_in   = geo_s4;
			assign clamp_in = clamp_s4;
			assign rem_in   = rem_s4;
			assign den_in   = den_s4;
			assign q_in     = '0;
		end else begin : g_next
			assign vld_in   = div_vld_s5[k-1];
			assign geo_in   = div_geo_s5[k-1];
			assign clamp_in = div_clamp_s5[k-1];
			assign rem_in   = div_rem_s5[k-1];
			assign den_in   = div_den_s5[k-1];
			assign q_in     = div_q_s5[k-1];
		end

		assign rem_sh = {rem_in[REM_W-2:0], 1'b0};
		assign fits   = rem_sh >= REM_W'(den_in);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s5[k] <= 1'b0;
			end else if (adv) begin
				div_vld_s5[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_geo_s5[k]   <= geo_in;
				div_clamp_s5[k] <= clamp_in;
				div_den_s5[k]   <= den_in;
				div_rem_s5[k]   <= fits ? (rem_sh - REM_W'(den_in)) : rem_sh;
				div_q_s5[k]     <= {q_in[FRACTION_BITS-2:0], fits};
			end
		end
	end

	// The two clamp cases never apply together.
	a_clamp_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> !(clamp_s4.zero && clamp_s4.full))
		else $error("clamp cases both set");

	// A quotient that is used comes with a remainder below the divisor.
	a_div_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		div_vld_s5[FRACTION_BITS-1] && !div_clamp_s5[FRACTION_BITS-1].zero &&
		!div_clamp_s5[FRACTION_BITS-1].full |->
		div_rem_s5[FRACTION_BITS-1] < REM_W'(div_den_s5[FRACTION_BITS-1]))
		else $error("divider remainder out of range");

	// A request accepted into the pipe reaches the first stage.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s1)
		else $error("accepted request not captured");

	// A result in the last internal stage moves into the output register.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s9 && adv |=> out_valid)
		else $error("result lost before output register");

endmodule

// ===== dv/tb_top.sv =====
// Testbench for point_segment_distance_squared: directed table, then random geometry.
// Depends on psds_pkg for the coordinate and fraction widths; checks each result against
// its directed value or a local model of the projection, clamp and rounding.
module tb_top;

	localparam int CW      = psds_pkg::DEFAULT_COORD_BITS;
	localparam int FW      = psds_pkg::DEFAULT_FRACTION_BITS;
	localparam int OW      = 2 * CW + 1;
	localparam int LATENCY = FW + 9;
	localparam int N_DIR   = 19;
	localparam int N_RAND  = 1880;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [OW-1:0] dist_t;

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} query_t;

	logic   clk = 1'b0;
	logic   arst_n;
	logic   in_valid;
	logic   in_ready;
	coord_t point_x;
	coord_t point_y;
	coord_t start_x;
	coord_t start_y;
	coord_t end_x;
	coord_t end_y;
	logic   out_valid;
	logic   out_ready = 1'b0;
	dist_t  distance_squared;

	dist_t dist_expected[$];
	int    fail_count;
	int    results_checked;
	int    zero_len_count;
	bit    quiet;

	// Directed rows: point, start, end. A negative expected value means the row
	// is checked against the model only.
	int dir_coords [N_DIR][6] = '{
		'{0, 0, 0, 0, 0, 0},
		'{3, 4, 0, 0, 0, 0},
		'{32767, 32767, -32768, -32768, -32768, -32768},
		'{-32768, -32768, 32767, 32767, 32767, 32767},
		'{-32768, 32767, 32767, -32768, 32767, -32768},
		'{-3, 4, 0, 0, 10, 0},
		'{13, 4, 0, 0, 10, 0},
		'{5, 7, 0, 0, 10, 0},
		'{10, 0, 0, 0, 10, 0},
		'{-7, 9, -7, 9, 100, -200},
		'{-6, 50, 0, 0, 0, 100},
		'{32767, -32768, -32768, -32768, 32767, 32767},
		'{0, 0, 32767, -32768, -32768, 32767},
		'{0, 32767, -32768, -32768, 32767, -32768},
		'{-1, -1, -1, -1, 0, 0},
		'{5, 1, 0, 0, 3, 7},
		'{-32768, 32767, 1, 1, 1, 1},
		'{-1, -1, -1, -1, -1, -1},
		'{0, 0, -32768, 0, 32767, 0}
	};
	longint dir_want [N_DIR] = '{
		0, 25, 64'd8589672450, 64'd8589672450, 64'd8589672450, 25, 25, 49, 0, 0,
		36, -1, -1, -1, 0, -1, 64'd2147418117, 0, 0
	};

	point_segment_distance_squared uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.point_x          (point_x),
		.point_y          (point_y),
		.start_x          (start_x),
		.start_y          (start_y),
		.end_x            (end_x),
		.end_y            (end_y),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.distance_squared (distance_squared)
	);

	always #5 clk = ~clk;

	// Project onto the segment, clamp the parameter, round the nearest point and
	// square the residual.
	function automatic dist_t predict_distance_sq(query_t q);
		longint px, py, dx, dy, dotp, len2, t, rem, half, vx, vy;
		px = longint'(q.point_x) - longint'(q.start_x);
		py = longint'(q.point_y) - longint'(q.start_y);
		dx = longint'(q.end_x) - longint'(q.start_x);
		dy = longint'(q.end_y) - longint'(q.start_y);
		dotp = px * dx + py * dy;
		len2 = dx * dx + dy * dy;
		t = 0;
		if (len2 <= 0 || dotp <= 0) begin
			t = 0;
		end else if (dotp >= len2) begin
			t = longint'(1) << FW;
		end else begin
			rem = dotp;
			for (int i = 0; i < FW; i++) begin
				rem = rem << 1;
				t = t << 1;
				if (rem >= len2) begin
					rem = rem - len2;
					t = t | 1;
				end
			end
		end
		half = longint'(1) << (FW - 1);
		// Arithmetic shift of a signed value floors, which gives ties toward plus infinity.
		vx = px - ((dx * t + half) >>> FW);
		vy = py - ((dy * t + half) >>> FW);
		return dist_t'(vx * vx + vy * vy);
	endfunction

	function automatic coord_t pick_extreme();
		case ($urandom_range(0, 5))
			0: return coord_t'(-32768);
			1: return coord_t'(32767);
			2: return coord_t'(0);
			3: return coord_t'(-1);
			4: return coord_t'(1);
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic coord_t jitter(coord_t base, int span);
		return coord_t'(int'(base) + int'($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic query_t draw_query();
		query_t q;
		int kind;
		coord_t bx, by;
		kind = $urandom_range(0, 99);
		q.point_x = coord_t'($urandom);
		q.point_y = coord_t'($urandom);
		q.start_x = coord_t'($urandom);
		q.start_y = coord_t'($urandom);
		q.end_x   = coord_t'($urandom);
		q.end_y   = coord_t'($urandom);
		if (kind < 45) begin
			// Fully random geometry.
		end else if (kind < 60) begin
			// A small cluster around a random base.
			bx = coord_t'($urandom);
			by = coord_t'($urandom);
			q.point_x = jitter(bx, 40);
			q.point_y = jitter(by, 40);
			q.start_x = jitter(bx, 40);
			q.start_y = jitter(by, 40);
			q.end_x   = jitter(bx, 40);
			q.end_y   = jitter(by, 40);
		end else if (kind < 70) begin
			q.end_x = q.start_x;
			q.end_y = q.start_y;
		end else if (kind < 80) begin
			q.point_x = pick_extreme();
			q.point_y = pick_extreme();
			q.start_x = pick_extreme();
			q.start_y = pick_extreme();
			q.end_x   = pick_extreme();
			q.end_y   = pick_extreme();
		end else if (kind < 90) begin
			// Near one of the endpoints, on either side of the clamp.
			if ($urandom_range(0, 1)) begin
				q.point_x = jitter(q.end_x, 8);
				q.point_y = jitter(q.end_y, 8);
			end else begin
				q.point_x = jitter(q.start_x, 8);
				q.point_y = jitter(q.start_y, 8);
			end
		end else begin
			// Close to the middle of the segment, where the rounding matters.
			bx = coord_t'((int'(q.start_x) + int'(q.end_x)) >>> 1);
			by = coord_t'((int'(q.start_y) + int'(q.end_y)) >>> 1);
			q.point_x = jitter(bx, 3);
			q.point_y = jitter(by, 3);
		end
		return q;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic issue_request(query_t q, longint want);
		while (!quiet && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		point_x  <= q.point_x;
		point_y  <= q.point_y;
		start_x  <= q.start_x;
		start_y  <= q.start_y;
		end_x    <= q.end_x;
		end_y    <= q.end_y;
		do @(posedge clk); while (!in_ready);
		if (want >= 0)
			dist_expected.push_back(dist_t'(want));
		else
			dist_expected.push_back(predict_distance_sq(q));
		if (q.start_x == q.end_x && q.start_y == q.end_y)
			zero_len_count++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (dist_expected.size() != 0)
			@(negedge clk);
	endtask

	always @(negedge clk) begin
		out_ready <= quiet || ($urandom_range(0, 99) >= 8);
	end

	always @(posedge clk) begin
		dist_t want;
		if (arst_n && out_valid && out_ready) begin
			if (dist_expected.size() == 0) begin
				$error("distance_squared: unexpected result %0d", distance_squared);
				fail_count++;
			end else begin
				want = dist_expected.pop_front();
				results_checked++;
				if (distance_squared !== want) begin
					$error("distance_squared: expected %0d, actual %0d", want,
						distance_squared);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		query_t q;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		point_x   = '0;
		point_y   = '0;
		start_x   = '0;
		start_y   = '0;
		end_x     = '0;
		end_y     = '0;
		fail_count      = 0;
		results_checked = 0;
		zero_len_count  = 0;
		quiet           = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < N_DIR; r++) begin
			q.point_x = coord_t'(dir_coords[r][0]);
			q.point_y = coord_t'(dir_coords[r][1]);
			q.start_x = coord_t'(dir_coords[r][2]);
			q.start_y = coord_t'(dir_coords[r][3]);
			q.end_x   = coord_t'(dir_coords[r][4]);
			q.end_y   = coord_t'(dir_coords[r][5]);
			issue_request(q, dir_want[r]);
		end
		// Let the pipeline empty completely before the random traffic.
		drain_results();

		for (int n = 0; n < N_RAND; n++) begin
			quiet = (n >= 400 && n < 800);
			if (n == 1200)
				drain_results();
			issue_request(draw_query(), -1);
		end
		quiet = 1'b0;
		in_valid <= 1'b0;
		while (dist_expected.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);

		$display("Sent %0d requests (%0d from the table), %0d with zero-length segments.",
			N_DIR + N_RAND, N_DIR, zero_len_count);
		$display("Checked %0d results with random stalls on both channels.",
			results_checked);
		if (fail_count == 0 && dist_expected.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/psds_pkg.sv
hdl/point_segment_distance_squared.sv
dv/tb_top.sv
